// ----- rtl/omni_drive_heading_mixer_defines.svh -----
// assertion macros shared by the heading mixer rtl
`ifndef OMNI_DRIVE_HEADING_MIXER_DEFINES_SVH
`define OMNI_DRIVE_HEADING_MIXER_DEFINES_SVH

// same-cycle implication
`define ODM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heading mixer check failed");

// next-cycle implication
`define ODM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heading mixer check failed");

`endif

// ----- rtl/odm_pkg.sv -----
package odm_pkg;

  localparam int MulAW = 34;
  localparam int MulBW = 18;
  localparam int MulPW = MulAW + MulBW;

  typedef logic signed [MulAW-1:0] mul_a_t;
  typedef logic signed [MulBW-1:0] mul_b_t;
  typedef logic signed [MulPW-1:0] mul_p_t;

  typedef enum logic [2:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_WEIGHT,
    REG_FULL_SCALE,
    REG_MIN_DRIVE,
    REG_WHEEL_TRIG,
    REG_WHEEL_SCALES
  } cfg_reg_t;

  function automatic logic signed [23:0] sat24(input mul_p_t v);
    logic signed [23:0] r;
    if (v > mul_p_t'(64'sd8388607)) begin
      r = 24'sh7FFFFF;
    end else if (v < mul_p_t'(-64'sd8388608)) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh07FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sh080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/odm_mul.sv -----
module odm_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  odm_pkg::mul_a_t a,
  input  odm_pkg::mul_b_t b,
  output logic            done,
  output odm_pkg::mul_p_t prod
);
  import odm_pkg::*;

  localparam int CntW = $clog2(MulBW);
  localparam logic [CntW-1:0] LastBit = CntW'(MulBW - 1);

  mul_p_t          mcand;
  mul_b_t          mplier;
  logic [CntW-1:0] cnt;
  logic            busy;

  // one multiplier bit per cycle, the top bit carries negative weight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand  <= {{(MulPW-MulAW){a[MulAW-1]}}, a};
        mplier <= b;
        prod   <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= (cnt == LastBit) ? prod - mcand : prod + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >>> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == LastBit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/omni_drive_heading_mixer.sv -----
// Four-wheel omni drive mixer with PID heading hold. One command word in,
// one word of four duty counts and four direction bits out. All multiplications
// run through a single bit-serial 34x18 multiplier: 31 products per
// command, one after another. The next command is taken as soon as the
// result sits in the output register, even while that result is stalled.
// Configuration writes are taken every cycle and must only happen while
// the block is idle. SINE_TABLE_ENTRIES is taken as a power of two.
`include "omni_drive_heading_mixer_defines.svh"

module omni_drive_heading_mixer #(
  parameter int PWM_BITS           = 13,
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  speed_command,
  input  logic [15:0]         travel_direction,
  input  logic [15:0]         target_heading,
  input  logic [15:0]         current_heading,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PWM_BITS-1:0] pwm_front_left,
  output logic [PWM_BITS-1:0] pwm_front_right,
  output logic [PWM_BITS-1:0] pwm_back_left,
  output logic [PWM_BITS-1:0] pwm_back_right,
  output logic                dir_front_left,
  output logic                dir_front_right,
  output logic                dir_back_left,
  output logic                dir_back_right
);
  import odm_pkg::*;

  localparam int SineBits = $clog2(SINE_TABLE_ENTRIES);
  localparam logic [15:0] AngMask = 16'(17'h10000 - (17'd1 << (16 - SineBits)));
  localparam logic [16:0] PwmMax = 17'((1 << PWM_BITS) - 1);

  typedef enum logic [1:0] {IDLE, ISSUE, WAIT, FIN} state_t;
  typedef enum logic [3:0] {
    ST_SIN_XX, ST_SIN_T1, ST_SIN_T2, ST_SIN_T3,
    ST_X1, ST_X2, ST_Y1, ST_Y2,
    ST_KI, ST_KP, ST_KD,
    ST_W_FS, ST_W_GAIN, ST_W_NEW, ST_W_OLD
  } step_t;

  state_t state;
  step_t  step;

  logic [31:0] kp, ki, kd, wheel_trig;
  logic [16:0] weight;
  logic [12:0] full_scale, min_drive;
  logic [63:0] wheel_scales;

  logic signed [31:0] integral;
  logic signed [15:0] last_err;
  logic signed [23:0] smoothed [4];

  logic signed [15:0] vel, err;
  logic [15:0]        dir, ang;
  logic               sin_sel;
  logic [15:0]        x2, t;
  logic signed [15:0] sdir, cdir;
  logic signed [31:0] p1;
  logic signed [16:0] xv, yv;
  logic signed [23:0] pterm;
  logic signed [33:0] turn;
  logic signed [23:0] n10, gterm;
  mul_p_t             accn;
  logic [1:0]         wheel;
  logic [PWM_BITS-1:0] pwm_w [4];
  logic               dir_w [4];

  logic   mul_start, mul_done;
  mul_a_t mul_a;
  mul_b_t mul_b;
  mul_p_t prod;

  odm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != IDLE);
  assign mul_start = (state == ISSUE);

  // quarter-wave folding of the quantized angle
  logic [15:0] p_ang;
  logic [1:0]  quad;
  logic [14:0] r_lo, r_eff;
  logic [15:0] x_val;
  assign p_ang = ang & AngMask;
  assign quad  = p_ang[15:14];
  assign r_lo  = {1'b0, p_ang[13:0]};
  assign r_eff = quad[0] ? 15'd16384 - r_lo : r_lo;
  assign x_val = {r_eff, 1'b0};

  logic signed [15:0] sw, cw, gain;
  logic [16:0]        w_eff, w_comp;
  logic signed [16:0] diff;
  logic signed [17:0] a_mix, b_mix;
  logic signed [33:0] cmd;
  assign sw     = wheel_trig[31:16];
  assign cw     = wheel_trig[15:0];
  assign gain   = wheel_scales[(3 - wheel) * 16 +: 16];
  assign w_eff  = (weight > 17'h10000) ? 17'h10000 : weight;
  assign w_comp = 17'h10000 - w_eff;
  assign diff   = {err[15], err} - {last_err[15], last_err};
  assign a_mix  = {xv[16], xv} + {yv[16], yv};
  assign b_mix  = {yv[16], yv} - {xv[16], xv};

  always_comb begin
    case (wheel)
      2'd0:    cmd = {{16{a_mix[17]}}, a_mix} + turn;
      2'd1:    cmd = {{16{b_mix[17]}}, b_mix} - turn;
      2'd2:    cmd = {{16{b_mix[17]}}, b_mix} + turn;
      default: cmd = {{16{a_mix[17]}}, a_mix} - turn;
    endcase
  end

  always_comb begin
    unique case (step)
      ST_SIN_XX: begin mul_a = {18'b0, x_val}; mul_b = {2'b0, x_val}; end
      ST_SIN_T1: begin mul_a = 34'sd2320;      mul_b = {2'b0, x2};    end
      ST_SIN_T2: begin mul_a = {18'b0, t};     mul_b = {2'b0, x2};    end
      ST_SIN_T3: begin mul_a = {18'b0, t};     mul_b = {2'b0, x_val}; end
      ST_X1: begin
        mul_a = {{18{sdir[15]}}, sdir}; mul_b = {{2{sw[15]}}, sw};
      end
      ST_X2: begin
        mul_a = {{2{p1[31]}}, p1};      mul_b = {{2{vel[15]}}, vel};
      end
      ST_Y1: begin
        mul_a = {{18{cdir[15]}}, cdir}; mul_b = {{2{cw[15]}}, cw};
      end
      ST_Y2: begin
        mul_a = {{2{p1[31]}}, p1};      mul_b = {{2{vel[15]}}, vel};
      end
      ST_KI: begin mul_a = {2'b0, ki}; mul_b = {{2{err[15]}}, err}; end
      ST_KP: begin mul_a = {2'b0, kp}; mul_b = {{2{err[15]}}, err}; end
      ST_KD: begin mul_a = {2'b0, kd}; mul_b = {diff[16], diff};    end
      ST_W_FS: begin mul_a = cmd; mul_b = {5'b0, full_scale}; end
      ST_W_GAIN: begin
        mul_a = {{10{n10[23]}}, n10}; mul_b = {{2{gain[15]}}, gain};
      end
      ST_W_NEW: begin
        mul_a = {{10{gterm[23]}}, gterm}; mul_b = {1'b0, w_eff};
      end
      ST_W_OLD: begin
        mul_a = {{10{smoothed[wheel][23]}}, smoothed[wheel]};
        mul_b = {1'b0, w_comp};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // sine result: clamp and mirror into the lower half wave
  logic [16:0]        sin_raw;
  logic [14:0]        sin_mag;
  logic signed [15:0] sin_val;
  assign sin_raw = prod[31:15];
  assign sin_mag = (sin_raw > 17'd32767) ? 15'h7FFF : sin_raw[14:0];
  assign sin_val = quad[1] ? -{1'b0, sin_mag} : {1'b0, sin_mag};

  // new smoothed value and its duty, rounded half away from zero
  logic signed [23:0] s_new;
  logic signed [24:0] s_ext, s_mag;
  logic [24:0]        s_rnd;
  logic [16:0]        m_val, m_min, m_sat;
  logic               s_pos;
  logic [PWM_BITS-1:0] duty;
  assign s_new = sat24((accn + prod) >>> 16);
  assign s_ext = {s_new[23], s_new};
  assign s_mag = s_new[23] ? -s_ext : s_ext;
  assign s_rnd = s_mag + 25'sd512;
  assign m_val = {2'b0, s_rnd[24:10]};
  assign s_pos = !s_new[23] && (m_val != 17'd0);
  assign m_min = (m_val < {4'b0, min_drive}) ? {4'b0, min_drive} : m_val;
  assign m_sat = (m_min > PwmMax) ? PwmMax : m_min;
  assign duty  = (m_val > 17'd150) ? m_sat[PWM_BITS-1:0] : '0;

  logic signed [33:0] int_sum;
  logic signed [25:0] dterm;
  assign int_sum = {{2{integral[31]}}, integral} + {{6{prod[51]}}, prod[51:24]};
  assign dterm   = prod[49:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      step         <= ST_SIN_XX;
      out_valid    <= 1'b0;
      kp           <= 32'd3019899;
      ki           <= 32'd0;
      kd           <= 32'd15099494;
      weight       <= 17'd16384;
      full_scale   <= 13'd8191;
      min_drive    <= 13'd0;
      wheel_trig   <= 32'd1518492290;
      wheel_scales <= 64'd4611756388245323776;
      integral     <= '0;
      last_err     <= '0;
      for (int i = 0; i < 4; i++) begin
        smoothed[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_KP:           kp           <= cfg_data[31:0];
          REG_KI:           ki           <= cfg_data[31:0];
          REG_KD:           kd           <= cfg_data[31:0];
          REG_WEIGHT:       weight       <= cfg_data[16:0];
          REG_FULL_SCALE:   full_scale   <= cfg_data[12:0];
          REG_MIN_DRIVE:    min_drive    <= cfg_data[12:0];
          REG_WHEEL_TRIG:   wheel_trig   <= cfg_data[31:0];
          REG_WHEEL_SCALES: wheel_scales <= cfg_data;
          default: ;
        endcase
      end

      // in FIN a taken word is replaced by the next one
      if (out_valid && !out_stall && state != FIN) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_valid) begin
            vel     <= speed_command;
            dir     <= travel_direction;
            ang     <= travel_direction;
            err     <= target_heading - current_heading;
            sin_sel <= 1'b0;
            step    <= ST_SIN_XX;
            state   <= ISSUE;
          end
        end
        ISSUE: state <= WAIT;
        WAIT: begin
          if (mul_done) begin
            if (step == ST_W_OLD && wheel == 2'd3) begin
              state <= FIN;
            end else begin
              state <= ISSUE;
            end
            unique case (step)
              ST_SIN_XX: begin x2 <= prod[30:15]; step <= ST_SIN_T1; end
              ST_SIN_T1: begin t <= 16'd21024 - prod[30:15]; step <= ST_SIN_T2; end
              ST_SIN_T2: begin t <= 16'd51472 - prod[30:15]; step <= ST_SIN_T3; end
              ST_SIN_T3: begin
                if (!sin_sel) begin
                  sdir    <= sin_val;
                  ang     <= dir + 16'h4000;
                  sin_sel <= 1'b1;
                  step    <= ST_SIN_XX;
                end else begin
                  cdir <= sin_val;
                  step <= ST_X1;
                end
              end
              ST_X1: begin p1 <= prod[31:0]; step <= ST_X2; end
              ST_X2: begin xv <= prod[46:30]; step <= ST_Y1; end
              ST_Y1: begin p1 <= prod[31:0]; step <= ST_Y2; end
              ST_Y2: begin yv <= prod[46:30]; step <= ST_KI; end
              ST_KI: begin integral <= sat32(int_sum); step <= ST_KP; end
              ST_KP: begin pterm <= prod[47:24]; step <= ST_KD; end
              ST_KD: begin
                turn     <= {{10{pterm[23]}}, pterm} + {{2{integral[31]}}, integral}
                            + {{8{dterm[25]}}, dterm};
                last_err <= err;
                wheel    <= 2'd0;
                step     <= ST_W_FS;
              end
              ST_W_FS:   begin n10 <= sat24(prod >>> 5); step <= ST_W_GAIN; end
              ST_W_GAIN: begin gterm <= sat24(prod >>> 14); step <= ST_W_NEW; end
              ST_W_NEW:  begin accn <= prod; step <= ST_W_OLD; end
              ST_W_OLD: begin
                smoothed[wheel] <= s_new;
                pwm_w[wheel]    <= duty;
                dir_w[wheel]    <= wheel[0] ? s_pos : !s_pos;
                step            <= ST_W_FS;
                if (wheel != 2'd3) begin
                  wheel <= wheel + 1'b1;
                end
              end
              default: step <= ST_SIN_XX;
            endcase
          end
        end
        FIN: begin
          if (!out_valid || !out_stall) begin
            pwm_front_left  <= pwm_w[0];
            pwm_front_right <= pwm_w[1];
            pwm_back_left   <= pwm_w[2];
            pwm_back_right  <= pwm_w[3];
            dir_front_left  <= dir_w[0];
            dir_front_right <= dir_w[1];
            dir_back_left   <= dir_w[2];
            dir_back_right  <= dir_w[3];
            out_valid       <= 1'b1;
            state           <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ODM_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == ISSUE)
  `ODM_ASSERT_SAME(a_done_in_wait, mul_done, state == WAIT)
  `ODM_ASSERT_NEXT(a_fin_loads, state == FIN && (!out_valid || !out_stall), out_valid && state == IDLE)

endmodule
